// ===== hw/rtl/psd_pkg.sv =====
// Shared types and constants for the power-sum block.
package psd_pkg;

  localparam int WORD_W = 64;
  localparam int HALF_W = 32;
  localparam int MID_W  = WORD_W + 2;
  localparam int OPS_W  = 21;

  localparam logic [WORD_W-1:0] ALL_ONES = {WORD_W{1'b1}};

  typedef enum logic [3:0] {
    S_IDLE,
    S_OPS,
    S_OPS_W,
    S_TERM,
    S_BIT,
    S_MUL_W,
    S_SQ,
    S_SQ_W,
    S_ADD,
    S_FIN
  } psd_state_t;

  typedef enum logic [1:0] {
    MP_IDLE,
    MP_LL,
    MP_HL,
    MP_LH
  } psd_mphase_t;

  typedef struct packed {
    logic done;
    logic ovf;
  } psd_mul_stat_t;

endpackage

// ===== hw/rtl/psd_mul.sv =====
// Saturation-aware 64x64 multiplier built on one 32x32 multiplier.
module psd_mul import psd_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [WORD_W-1:0] op_a,
  input  logic [WORD_W-1:0] op_b,
  output logic [WORD_W-1:0] prod,
  output psd_mul_stat_t     stat
);

  psd_mphase_t       phase_r, phase_nxt;
  logic [WORD_W-1:0] a_r, a_nxt;
  logic [WORD_W-1:0] b_r, b_nxt;
  logic [HALF_W-1:0] lo_r, lo_nxt;
  logic [MID_W-1:0]  mid_r, mid_nxt;
  logic              done_r, done_nxt;
  logic              ovf_r, ovf_nxt;

  logic [HALF_W-1:0] a_hi, a_lo, b_hi, b_lo;
  logic [HALF_W-1:0] mul_x, mul_y;
  logic [WORD_W-1:0] pp;
  logic [MID_W-1:0]  mid_sum;

  assign a_hi = a_r[WORD_W-1:HALF_W];
  assign a_lo = a_r[HALF_W-1:0];
  assign b_hi = b_r[WORD_W-1:HALF_W];
  assign b_lo = b_r[HALF_W-1:0];

  always_comb begin
    unique case (phase_r)
      MP_HL: begin
        mul_x = a_hi;
        mul_y = b_lo;
      end
      MP_LH: begin
        mul_x = a_lo;
        mul_y = b_hi;
      end
      default: begin
        mul_x = a_lo;
        mul_y = b_lo;
      end
    endcase
  end

  assign pp      = WORD_W'(mul_x) * WORD_W'(mul_y);
  assign mid_sum = mid_r + MID_W'(pp);

  always_comb begin
    phase_nxt = phase_r;
    a_nxt     = a_r;
    b_nxt     = b_r;
    lo_nxt    = lo_r;
    mid_nxt   = mid_r;
    done_nxt  = 1'b0;
    ovf_nxt   = ovf_r;
    unique case (phase_r)
      MP_IDLE: begin
        if (start) begin
          a_nxt     = op_a;
          b_nxt     = op_b;
          phase_nxt = MP_LL;
        end
      end
      MP_LL: begin
        lo_nxt  = pp[HALF_W-1:0];
        mid_nxt = MID_W'(pp[WORD_W-1:HALF_W]);
        if ((a_hi != '0) && (b_hi != '0)) begin
          ovf_nxt   = 1'b1;
          done_nxt  = 1'b1;
          phase_nxt = MP_IDLE;
        end else if (a_hi != '0) begin
          phase_nxt = MP_HL;
        end else if (b_hi != '0) begin
          phase_nxt = MP_LH;
        end else begin
          ovf_nxt   = 1'b0;
          done_nxt  = 1'b1;
          phase_nxt = MP_IDLE;
        end
      end
      MP_HL: begin
        mid_nxt = mid_sum;
        if (b_hi != '0) begin
          phase_nxt = MP_LH;
        end else begin
          ovf_nxt   = (mid_sum[MID_W-1:HALF_W] != '0);
          done_nxt  = 1'b1;
          phase_nxt = MP_IDLE;
        end
      end
      MP_LH: begin
        mid_nxt   = mid_sum;
        ovf_nxt   = (mid_sum[MID_W-1:HALF_W] != '0);
        done_nxt  = 1'b1;
        phase_nxt = MP_IDLE;
      end
      default: phase_nxt = MP_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= MP_IDLE;
      done_r  <= 1'b0;
    end else begin
      phase_r <= phase_nxt;
      done_r  <= done_nxt;
    end
    a_r   <= a_nxt;
    b_r   <= b_nxt;
    lo_r  <= lo_nxt;
    mid_r <= mid_nxt;
    ovf_r <= ovf_nxt;
  end

  assign prod      = {mid_r[HALF_W-1:0], lo_r};
  assign stat.done = done_r;
  assign stat.ovf  = ovf_r;

endmodule

// ===== hw/rtl/power_sum_direct.sv =====
// Top level of the power-sum block: sequencer, sum accumulator and result register.
// Sum of k^p for k = 1..n, each power built by right-to-left square-and-multiply
// with 64-bit saturation; the sum saturates to all ones with the saturated flag set.
// One request is processed at a time: in_stall is high from acceptance until the
// result is loaded into the output register. All products go through one shared
// 32x32 multiplier, one pass when both operands fit 32 bits or both exceed it (an
// overflow), and two when only one does. Each term walks the exponent bits up to
// the top set bit, using at most 2*P_WIDTH-2 multiplies and squarings (fewer when
// the running product is still 1 or has overflowed); summing stops at the first
// overflow, and a result waits while the output register is stalled. op_count is
// n*(3*L + W + 1) kept to 21 bits, L the bit length and W the ones count of p_exp.
// n of 0 returns a sum of 0 with no terms computed.
module power_sum_direct import psd_pkg::*; #(
  parameter int N_WIDTH = 16,
  parameter int P_WIDTH = 6
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [N_WIDTH-1:0] in_n,
  input  logic [P_WIDTH-1:0] in_p_exp,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [WORD_W-1:0]  out_power_sum,
  output logic               out_saturated,
  output logic [OPS_W-1:0]   out_op_count
);

  localparam int PT_W = $clog2(4 * P_WIDTH + 2);
  localparam int BC_W = $clog2(P_WIDTH + 1);

  psd_state_t         state_r, state_nxt;
  logic [N_WIDTH-1:0] n_r, n_nxt;
  logic [P_WIDTH-1:0] p_r, p_nxt;
  logic [P_WIDTH-1:0] e_r, e_nxt;
  logic [N_WIDTH-1:0] k_r, k_nxt;
  logic [WORD_W-1:0]  acc_r, acc_nxt;
  logic [WORD_W-1:0]  sq_r, sq_nxt;
  logic               acc_ovf_r, acc_ovf_nxt;
  logic               sq_ovf_r, sq_ovf_nxt;
  logic [WORD_W-1:0]  sum_r, sum_nxt;
  logic               sat_r, sat_nxt;
  logic [OPS_W-1:0]   ops_r, ops_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic [WORD_W-1:0]  out_sum_r, out_sum_nxt;
  logic               out_sat_r, out_sat_nxt;
  logic [OPS_W-1:0]   out_ops_r, out_ops_nxt;

  logic               mul_start;
  logic [WORD_W-1:0]  mul_a, mul_b, mul_prod;
  psd_mul_stat_t      mul_stat;

  logic [BC_W-1:0]    bit_len, ones_cnt;
  logic [PT_W-1:0]    per_term;
  logic [WORD_W:0]    sum_ext;

  psd_mul u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .start (mul_start),
    .op_a  (mul_a),
    .op_b  (mul_b),
    .prod  (mul_prod),
    .stat  (mul_stat)
  );

  always_comb begin
    bit_len  = '0;
    ones_cnt = '0;
    for (int i = 0; i < P_WIDTH; i++) begin
      if (p_r[i]) begin
        bit_len  = BC_W'(i + 1);
        ones_cnt = ones_cnt + 1'b1;
      end
    end
    per_term = PT_W'(3) * PT_W'(bit_len) + PT_W'(ones_cnt) + PT_W'(1);
  end

  assign sum_ext = {1'b0, sum_r} + {1'b0, acc_r};

  always_comb begin
    state_nxt     = state_r;
    n_nxt         = n_r;
    p_nxt         = p_r;
    e_nxt         = e_r;
    k_nxt         = k_r;
    acc_nxt       = acc_r;
    sq_nxt        = sq_r;
    acc_ovf_nxt   = acc_ovf_r;
    sq_ovf_nxt    = sq_ovf_r;
    sum_nxt       = sum_r;
    sat_nxt       = sat_r;
    ops_nxt       = ops_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_sum_nxt   = out_sum_r;
    out_sat_nxt   = out_sat_r;
    out_ops_nxt   = out_ops_r;
    mul_start     = 1'b0;
    mul_a         = acc_r;
    mul_b         = sq_r;
    in_stall      = 1'b1;

    unique case (state_r)
      S_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          n_nxt     = in_n;
          p_nxt     = in_p_exp;
          state_nxt = S_OPS;
        end
      end
      S_OPS: begin
        mul_a     = WORD_W'(n_r);
        mul_b     = WORD_W'(per_term);
        mul_start = 1'b1;
        state_nxt = S_OPS_W;
      end
      S_OPS_W: begin
        if (mul_stat.done) begin
          ops_nxt = mul_prod[OPS_W-1:0];
          k_nxt   = N_WIDTH'(1);
          sum_nxt = '0;
          sat_nxt = 1'b0;
          state_nxt = (n_r == '0) ? S_FIN : S_TERM;
        end
      end
      S_TERM: begin
        acc_nxt     = WORD_W'(1);
        sq_nxt      = WORD_W'(k_r);
        acc_ovf_nxt = 1'b0;
        sq_ovf_nxt  = 1'b0;
        e_nxt       = p_r;
        state_nxt   = (p_r == '0) ? S_ADD : S_BIT;
      end
      S_BIT: begin
        if (!e_r[0] || acc_ovf_r) begin
          state_nxt = S_SQ;
        end else if (sq_ovf_r) begin
          acc_ovf_nxt = 1'b1;
          acc_nxt     = ALL_ONES;
          state_nxt   = S_SQ;
        end else if (acc_r == WORD_W'(1)) begin
          acc_nxt   = sq_r;
          state_nxt = S_SQ;
        end else begin
          mul_start = 1'b1;
          state_nxt = S_MUL_W;
        end
      end
      S_MUL_W: begin
        if (mul_stat.done) begin
          acc_ovf_nxt = mul_stat.ovf;
          acc_nxt     = mul_stat.ovf ? ALL_ONES : mul_prod;
          state_nxt   = S_SQ;
        end
      end
      S_SQ: begin
        if ((e_r[P_WIDTH-1:1] == '0) || acc_ovf_r) begin
          state_nxt = S_ADD;
        end else if (sq_ovf_r) begin
          e_nxt     = e_r >> 1;
          state_nxt = S_BIT;
        end else begin
          mul_a     = sq_r;
          mul_b     = sq_r;
          mul_start = 1'b1;
          state_nxt = S_SQ_W;
        end
      end
      S_SQ_W: begin
        if (mul_stat.done) begin
          sq_ovf_nxt = mul_stat.ovf;
          sq_nxt     = mul_prod;
          e_nxt      = e_r >> 1;
          state_nxt  = S_BIT;
        end
      end
      S_ADD: begin
        if (acc_ovf_r || sum_ext[WORD_W]) begin
          sat_nxt   = 1'b1;
          sum_nxt   = ALL_ONES;
          state_nxt = S_FIN;
        end else begin
          sum_nxt = sum_ext[WORD_W-1:0];
          if (k_r == n_r) begin
            state_nxt = S_FIN;
          end else begin
            k_nxt     = k_r + 1'b1;
            state_nxt = S_TERM;
          end
        end
      end
      S_FIN: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt = 1'b1;
          out_sum_nxt   = sum_r;
          out_sat_nxt   = sat_r;
          out_ops_nxt   = ops_r;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
    n_r       <= n_nxt;
    p_r       <= p_nxt;
    e_r       <= e_nxt;
    k_r       <= k_nxt;
    acc_r     <= acc_nxt;
    sq_r      <= sq_nxt;
    acc_ovf_r <= acc_ovf_nxt;
    sq_ovf_r  <= sq_ovf_nxt;
    sum_r     <= sum_nxt;
    sat_r     <= sat_nxt;
    ops_r     <= ops_nxt;
    out_sum_r <= out_sum_nxt;
    out_sat_r <= out_sat_nxt;
    out_ops_r <= out_ops_nxt;
  end

  assign out_valid     = out_valid_r;
  assign out_power_sum = out_sum_r;
  assign out_saturated = out_sat_r;
  assign out_op_count  = out_ops_r;

endmodule
